/* rtl/core/assert_macros.svh */
// Assertion macros shared by the grid window displacement RTL.
// Depends on nothing; each macro expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gwfd_pkg.sv */
// Package for the grid window falloff displacement core: widths, payload types,
// register indexes, axis codes and the sine coefficients. Depends on nothing.
package gwfd_pkg;

    localparam int INDEX_BITS   = 24;
    localparam int WIDTH_BITS   = 13;
    localparam int SCALE_BITS   = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_WIDTH     = 3'd0,
        CFG_ROW_BOUND_A    = 3'd1,
        CFG_ROW_BOUND_B    = 3'd2,
        CFG_COLUMN_BOUND_A = 3'd3,
        CFG_COLUMN_BOUND_B = 3'd4,
        CFG_FALLOFF_SCALES = 3'd5,
        CFG_PEAK_DELTA     = 3'd6,
        CFG_MODE           = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        AXIS_NONE = 2'd0,
        AXIS_X    = 2'd1,
        AXIS_Y    = 2'd2,
        AXIS_Z    = 2'd3
    } axis_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] vertex_index;
        logic signed [31:0]    in_x;
        logic signed [31:0]    in_y;
        logic signed [31:0]    in_z;
    } vtx_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               in_window;
        logic signed [31:0] applied_delta;
    } res_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } coord_t;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [30:0] SINE_C9 = 31'd172272;
    localparam logic [30:0] SINE_C7 = 31'd5026995;
    localparam logic [30:0] SINE_C5 = 31'd85569306;
    localparam logic [30:0] SINE_C3 = 31'd693598668;
    localparam logic [30:0] SINE_C1 = 31'd1686629713;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -35'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* rtl/core/gwfd_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the divisor is held steady by the configuration.
module gwfd_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 13,
    parameter int QUO_W = 24,
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem,
    output logic [PAY_W-1:0] pay_out
);
    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CW-1:0]    rem_reg  [QUO_W];
    logic [CW-1:0]    rem_next [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic [QUO_W-1:0] quo_next [QUO_W];
    logic [PAY_W-1:0] pay_reg  [QUO_W];
    logic             vld_reg  [QUO_W];

    always_comb
    begin
        logic [CW-1:0]    r_src;
        logic [CW-1:0]    d_sh;
        logic [QUO_W-1:0] q_src;
        for (int s = 0; s < QUO_W; s++)
        begin
            if (s == 0)
            begin
                r_src = CW'(num);
                q_src = '0;
            end
            else
            begin
                r_src = rem_reg[s-1];
                q_src = quo_reg[s-1];
            end
            d_sh        = CW'(den) << (QUO_W - 1 - s);
            rem_next[s] = r_src;
            quo_next[s] = q_src;
            if (r_src >= d_sh)
            begin
                rem_next[s]               = r_src - d_sh;
                quo_next[s][QUO_W-1-s]    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QUO_W; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < QUO_W; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= pay_in;
            for (int s = 0; s < QUO_W; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
            for (int s = 1; s < QUO_W; s++)
            begin
                pay_reg[s] <= pay_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign rem       = rem_reg[QUO_W-1][DEN_W-1:0];
    assign pay_out   = pay_reg[QUO_W-1];

endmodule

/* rtl/core/gwfd_sqrt.sv */
// Pipelined integer square root of a 32-bit radicand, one root bit per stage.
// Depends on nothing.
module gwfd_sqrt #(
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [31:0]      radicand,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [15:0]      root,
    output logic [PAY_W-1:0] pay_out
);
    localparam int STEPS = 16;

    logic [31:0]      v_reg   [STEPS];
    logic [31:0]      v_next  [STEPS];
    logic [31:0]      r_reg   [STEPS];
    logic [31:0]      r_next  [STEPS];
    logic [PAY_W-1:0] pay_reg [STEPS];
    logic             vld_reg [STEPS];

    always_comb
    begin
        logic [31:0] v_src;
        logic [31:0] r_src;
        logic [31:0] b;
        logic [32:0] trial;
        for (int s = 0; s < STEPS; s++)
        begin
            if (s == 0)
            begin
                v_src = radicand;
                r_src = '0;
            end
            else
            begin
                v_src = v_reg[s-1];
                r_src = r_reg[s-1];
            end
            b     = 32'd1 << (2 * (STEPS - 1 - s));
            trial = {1'b0, r_src} + {1'b0, b};
            if ({1'b0, v_src} >= trial)
            begin
                v_next[s] = v_src - trial[31:0];
                r_next[s] = (r_src >> 1) + b;
            end
            else
            begin
                v_next[s] = v_src;
                r_next[s] = r_src >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STEPS; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < STEPS; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= pay_in;
            for (int s = 0; s < STEPS; s++)
            begin
                v_reg[s] <= v_next[s];
                r_reg[s] <= r_next[s];
            end
            for (int s = 1; s < STEPS; s++)
            begin
                pay_reg[s] <= pay_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign root      = r_reg[STEPS-1][15:0];
    assign pay_out   = pay_reg[STEPS-1];

endmodule

/* rtl/core/gwfd_sine.sv */
// Pipelined quarter-wave sine: Horner evaluation with one multiply or one
// subtract per stage. Depends on gwfd_pkg for the coefficients.
module gwfd_sine #(
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  logic [16:0]      alpha,
    input  logic [PAY_W-1:0] pay_in,
    output logic             out_valid,
    output logic [16:0]      sine,
    output logic [PAY_W-1:0] pay_out
);
    import gwfd_pkg::*;

    localparam int STAGES = 11;

    logic [61:0]      data_reg  [STAGES];
    logic [61:0]      data_next [STAGES];
    logic [29:0]      t2_reg    [STAGES];
    logic [29:0]      t2_next   [STAGES];
    logic [16:0]      alp_reg   [STAGES];
    logic [16:0]      alp_next  [STAGES];
    logic [PAY_W-1:0] pay_reg   [STAGES];
    logic             vld_reg   [STAGES];

    always_comb
    begin
        logic [61:0] d_src;
        logic [29:0] t_src;
        logic [16:0] a_src;
        logic [31:0] sq;
        logic [30:0] coef;
        for (int s = 0; s < STAGES; s++)
        begin
            if (s == 0)
            begin
                d_src = '0;
                t_src = '0;
                a_src = alpha;
            end
            else
            begin
                d_src = data_reg[s-1];
                t_src = t2_reg[s-1];
                a_src = alp_reg[s-1];
            end
            case (s)
                2:       coef = SINE_C7;
                4:       coef = SINE_C5;
                6:       coef = SINE_C3;
                default: coef = SINE_C1;
            endcase
            sq          = a_src[15:0] * a_src[15:0];
            t2_next[s]  = t_src;
            alp_next[s] = a_src;
            if (s == 0)
            begin
                t2_next[s]   = sq[31:2];
                data_next[s] = 62'(SINE_C9);
            end
            else if (s == 9)
            begin
                data_next[s] = 62'(d_src[30:0]) * 62'(a_src[15:0]);
            end
            else if (s == 10)
            begin
                if (a_src[16] || (d_src[61:30] > 32'(ONE_Q16)))
                begin
                    data_next[s] = 62'(ONE_Q16);
                end
                else
                begin
                    data_next[s] = 62'(d_src[61:30]);
                end
            end
            else if (s % 2 == 1)
            begin
                data_next[s] = 62'(d_src[30:0]) * 62'(t_src);
            end
            else
            begin
                data_next[s] = 62'(coef) - 62'(d_src[61:30]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pay_reg[0] <= pay_in;
            for (int s = 0; s < STAGES; s++)
            begin
                data_reg[s] <= data_next[s];
                t2_reg[s]   <= t2_next[s];
                alp_reg[s]  <= alp_next[s];
            end
            for (int s = 1; s < STAGES; s++)
            begin
                pay_reg[s] <= pay_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign sine      = data_reg[STAGES-1][16:0];
    assign pay_out   = pay_reg[STAGES-1];

endmodule

/* rtl/core/grid_window_falloff_displace_core.sv */
// Top level of the grid window falloff displacement core.
// Depends on gwfd_pkg, gwfd_div, gwfd_sqrt, gwfd_sine and assert_macros.svh.
//
// Use: vertices arrive on the vtx channel (vtx_valid, vtx_stall, vtx) and one
// result per vertex leaves on the res channel (res_valid, res_stall, res), in
// order. A transaction takes place at a rising edge with valid high and stall
// low. Registers are written through cfg_we, cfg_index and cfg_data; the user
// must write them only while the core is idle, which the core does not enforce.
// The path from the accepting edge to res_valid runs through the row and column
// division, the window stage, the two ramp divisions in parallel, the square
// stages, the square root, the sine, the delta stages and the output buffer.
// Throughput is one vertex per cycle while the output buffer is not full; the
// bit-per-stage dividers and root extractor are fully pipelined.
// Reset clears every valid bit and the output buffer and loads the register
// defaults. When the receiver stalls, a two-entry output buffer absorbs the
// results in flight; once it is full the whole pipeline holds and vtx_stall
// rises, so nothing is lost or repeated.
`include "assert_macros.svh"

module grid_window_falloff_displace_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gwfd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [gwfd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                vtx_valid,
    output logic                                vtx_stall,
    input  gwfd_pkg::vtx_t                      vtx,
    output logic                                res_valid,
    input  logic                                res_stall,
    output gwfd_pkg::res_t                      res
);
    import gwfd_pkg::*;

    localparam int NUM_C_W = WIDTH_BITS + SCALE_BITS;
    localparam int NUM_R_W = INDEX_BITS + SCALE_BITS;
    localparam int PASS_W  = $bits(coord_t) + 1;

    logic [WIDTH_BITS-1:0] grid_width_reg;
    logic [INDEX_BITS-1:0] row_bound_a_reg;
    logic [INDEX_BITS-1:0] row_bound_b_reg;
    logic [WIDTH_BITS-1:0] column_bound_a_reg;
    logic [WIDTH_BITS-1:0] column_bound_b_reg;
    logic [31:0]           falloff_scales_reg;
    logic signed [31:0]    peak_delta_reg;
    logic [2:0]            mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg     <= WIDTH_BITS'(1);
            row_bound_a_reg    <= '0;
            row_bound_b_reg    <= '0;
            column_bound_a_reg <= '0;
            column_bound_b_reg <= '0;
            falloff_scales_reg <= 32'h1000_1000;
            peak_delta_reg     <= '0;
            mode_reg           <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GRID_WIDTH:     grid_width_reg     <= cfg_data[WIDTH_BITS-1:0];
                CFG_ROW_BOUND_A:    row_bound_a_reg    <= cfg_data[INDEX_BITS-1:0];
                CFG_ROW_BOUND_B:    row_bound_b_reg    <= cfg_data[INDEX_BITS-1:0];
                CFG_COLUMN_BOUND_A: column_bound_a_reg <= cfg_data[WIDTH_BITS-1:0];
                CFG_COLUMN_BOUND_B: column_bound_b_reg <= cfg_data[WIDTH_BITS-1:0];
                CFG_FALLOFF_SCALES: falloff_scales_reg <= cfg_data[31:0];
                CFG_PEAK_DELTA:     peak_delta_reg     <= cfg_data[31:0];
                CFG_MODE:           mode_reg           <= cfg_data[2:0];
                default:            mode_reg           <= mode_reg;
            endcase
        end
    end

    logic [WIDTH_BITS-1:0] width_eff;
    logic [INDEX_BITS-1:0] rmin;
    logic [INDEX_BITS-1:0] rmax;
    logic [WIDTH_BITS-1:0] cmin;
    logic [WIDTH_BITS-1:0] cmax;
    logic                  row_inv;
    logic                  col_inv;

    assign width_eff = (grid_width_reg == '0) ? WIDTH_BITS'(1) : grid_width_reg;
    assign row_inv   = row_bound_a_reg > row_bound_b_reg;
    assign col_inv   = column_bound_a_reg > column_bound_b_reg;
    assign rmin      = row_inv ? row_bound_b_reg : row_bound_a_reg;
    assign rmax      = row_inv ? row_bound_a_reg : row_bound_b_reg;
    assign cmin      = col_inv ? column_bound_b_reg : column_bound_a_reg;
    assign cmax      = col_inv ? column_bound_a_reg : column_bound_b_reg;

    // Output buffer and the pipeline-wide advance.
    res_t       buf_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       adv;
    logic       push;
    logic       pop;
    res_t       res_next;

    assign adv       = cnt_reg != 2'd2;
    assign vtx_stall = !adv;

    // Row and column of the vertex.
    coord_t                coord_in;
    logic                  idx_valid;
    logic [INDEX_BITS-1:0] idx_row;
    logic [WIDTH_BITS-1:0] idx_col;
    coord_t                idx_coord;

    assign coord_in = '{x: vtx.in_x, y: vtx.in_y, z: vtx.in_z};

    gwfd_div #(
        .NUM_W (INDEX_BITS),
        .DEN_W (WIDTH_BITS),
        .QUO_W (INDEX_BITS),
        .PAY_W ($bits(coord_t))
    ) u_idx_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (vtx_valid),
        .num       (vtx.vertex_index),
        .den       (width_eff),
        .pay_in    (coord_in),
        .out_valid (idx_valid),
        .quo       (idx_row),
        .rem       (idx_col),
        .pay_out   (idx_coord)
    );

    // Window test and ramp numerators.
    logic                 a_valid_reg;
    logic                 a_inside_reg;
    coord_t               a_coord_reg;
    logic [NUM_C_W-1:0]   a_num_c_reg;
    logic [NUM_R_W-1:0]   a_num_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= idx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_inside_reg <= (idx_row >= rmin) && (idx_row < rmax) &&
                            (idx_col >= cmin) && (idx_col < cmax);
            a_coord_reg  <= idx_coord;
            a_num_c_reg  <= NUM_C_W'(idx_col - cmin) * NUM_C_W'(falloff_scales_reg[15:0]);
            a_num_r_reg  <= NUM_R_W'(idx_row - rmin) * NUM_R_W'(falloff_scales_reg[31:16]);
        end
    end

    logic                  rc_valid;
    logic                  rr_valid;
    logic [SCALE_BITS-1:0] ramp_c;
    logic [SCALE_BITS-1:0] ramp_r;
    coord_t                rc_coord;
    logic                  rr_inside;

    gwfd_div #(
        .NUM_W (NUM_C_W),
        .DEN_W (WIDTH_BITS),
        .QUO_W (SCALE_BITS),
        .PAY_W ($bits(coord_t))
    ) u_col_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (a_valid_reg),
        .num       (a_num_c_reg),
        .den       (cmax - cmin),
        .pay_in    (a_coord_reg),
        .out_valid (rc_valid),
        .quo       (ramp_c),
        .rem       (),
        .pay_out   (rc_coord)
    );

    gwfd_div #(
        .NUM_W (NUM_R_W),
        .DEN_W (INDEX_BITS),
        .QUO_W (SCALE_BITS),
        .PAY_W (1)
    ) u_row_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (a_valid_reg),
        .num       (a_num_r_reg),
        .den       (rmax - rmin),
        .pay_in    (a_inside_reg),
        .out_valid (rr_valid),
        .quo       (ramp_r),
        .rem       (),
        .pay_out   (rr_inside)
    );

    // Squared magnitude of the two ramps.
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic [16:0]        ux;
    logic [16:0]        uy;

    assign ax = col_inv ? 18'sd4096 - $signed({2'b00, ramp_c}) : $signed({2'b00, ramp_c});
    assign ay = row_inv ? 18'sd4096 - $signed({2'b00, ramp_r}) : $signed({2'b00, ramp_r});
    assign ux = ax[17] ? 17'(-ax) : 17'(ax);
    assign uy = ay[17] ? 17'(-ay) : 17'(ay);

    logic              m1_valid_reg;
    logic [PASS_W-1:0] m1_pass_reg;
    logic [33:0]       m1_sqx_reg;
    logic [33:0]       m1_sqy_reg;
    logic              m2_valid_reg;
    logic [PASS_W-1:0] m2_pass_reg;
    logic              m2_big_reg;
    logic [31:0]       m2_rad_reg;
    logic [34:0]       s2_sum;

    assign s2_sum = 35'(m1_sqx_reg) + 35'(m1_sqy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= rc_valid && rr_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_pass_reg <= {rr_inside, rc_coord};
            m1_sqx_reg  <= ux * ux;
            m1_sqy_reg  <= uy * uy;
            m2_pass_reg <= m1_pass_reg;
            m2_big_reg  <= |s2_sum[34:24];
            m2_rad_reg  <= {s2_sum[23:0], 8'h00};
        end
    end

    logic              sq_valid;
    logic [15:0]       sq_root;
    logic [PASS_W:0]   sq_pay;
    logic [16:0]       alpha;

    gwfd_sqrt #(
        .PAY_W (PASS_W + 1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (m2_valid_reg),
        .radicand  (m2_rad_reg),
        .pay_in    ({m2_big_reg, m2_pass_reg}),
        .out_valid (sq_valid),
        .root      (sq_root),
        .pay_out   (sq_pay)
    );

    assign alpha = sq_pay[PASS_W] ? ONE_Q16 : {1'b0, sq_root};

    logic              sn_valid;
    logic [16:0]       sn_val;
    logic [PASS_W-1:0] sn_pass;

    gwfd_sine #(
        .PAY_W (PASS_W)
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .alpha     (alpha),
        .pay_in    (sq_pay[PASS_W-1:0]),
        .out_valid (sn_valid),
        .sine      (sn_val),
        .pay_out   (sn_pass)
    );

    // Delta from the peak, then the optional inversion.
    logic signed [17:0] one_minus;
    logic               d1_valid_reg;
    logic [PASS_W-1:0]  d1_pass_reg;
    logic signed [49:0] d1_mul_reg;
    logic               d2_valid_reg;
    logic [PASS_W-1:0]  d2_pass_reg;
    logic signed [31:0] d2_delta_reg;
    logic signed [33:0] d_floor;

    assign one_minus = $signed(18'(ONE_Q16) - 18'(sn_val));
    assign d_floor   = d1_mul_reg[49:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg <= 1'b0;
            d2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d1_valid_reg <= sn_valid;
            d2_valid_reg <= d1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_pass_reg  <= sn_pass;
            d1_mul_reg   <= 50'(peak_delta_reg) * 50'(one_minus);
            d2_pass_reg  <= d1_pass_reg;
            d2_delta_reg <= mode_reg[2] ? sat32(35'sd65536 - 35'(d_floor)) : sat32(35'(d_floor));
        end
    end

    // Final add onto the selected axis.
    coord_t             d2_coord;
    logic               d2_inside;
    logic signed [31:0] delta_used;

    assign d2_coord   = d2_pass_reg[PASS_W-2:0];
    assign d2_inside  = d2_pass_reg[PASS_W-1];
    assign delta_used = d2_inside ? d2_delta_reg : 32'sd0;

    always_comb
    begin
        res_next.out_x         = d2_coord.x;
        res_next.out_y         = d2_coord.y;
        res_next.out_z         = d2_coord.z;
        res_next.in_window     = d2_inside;
        res_next.applied_delta = delta_used;
        case (axis_t'(mode_reg[1:0]))
            AXIS_X:  res_next.out_x = sat32(35'(d2_coord.x) + 35'(delta_used));
            AXIS_Y:  res_next.out_y = sat32(35'(d2_coord.y) + 35'(delta_used));
            AXIS_Z:  res_next.out_z = sat32(35'(d2_coord.z) + 35'(delta_used));
            default: res_next.out_x = d2_coord.x;
        endcase
    end

    assign push      = adv && d2_valid_reg;
    assign pop       = res_valid && !res_stall;
    assign res_valid = cnt_reg != 2'd0;
    assign res       = buf_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res_next;
        end
    end

    `ASSERT_IMPLIES(a_no_overflow, push, cnt_reg != 2'd2, "result pushed into a full buffer")
    `ASSERT_IMPLIES(a_outside_zero, res_valid && !res.in_window,
                    res.applied_delta == 32'sd0, "nonzero delta outside the window")
    `ASSERT_NEXT(a_hold_on_stall, !adv && rst_n,
                 $stable(d2_valid_reg) && $stable(d2_delta_reg),
                 "pipeline moved while held")

endmodule
